[hdl/drp_pkg.sv]
`timescale 1ns / 1ps
// Types, constants and codes shared by the DHCP reply parser.
package drp_pkg;

    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_TRANSACTION_ID = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LISTEN_MODE    = 8'd1;

    localparam logic [1:0] MODE_IDLE       = 2'd0;
    localparam logic [1:0] MODE_WAIT_OFFER = 2'd1;
    localparam logic [1:0] MODE_WAIT_ACK   = 2'd2;

    localparam logic [1:0] VERDICT_NONE  = 2'd0;
    localparam logic [1:0] VERDICT_OFFER = 2'd1;
    localparam logic [1:0] VERDICT_ACK   = 2'd2;

    localparam logic [15:0] OPT_FIRST = 16'd240;
    localparam logic [15:0] MIN_LEN   = 16'd237;
    localparam logic [7:0]  OP_REPLY  = 8'd2;
    localparam logic [7:0]  OPT_PAD_END = 8'h00;
    localparam logic [7:0]  OPT_NETMASK = 8'd1;
    localparam logic [7:0]  OPT_ROUTER  = 8'd3;
    localparam logic [7:0]  OPT_MSGTYPE = 8'd53;
    localparam logic [7:0]  OPT_SERVER  = 8'd54;
    localparam logic [7:0]  MT_OFFER  = 8'd2;
    localparam logic [7:0]  MT_ACK    = 8'd5;
    localparam logic [7:0]  LEN_MSGTYPE = 8'd1;
    localparam logic [7:0]  LEN_ADDR    = 8'd4;

    localparam logic [15:0] POS_OP       = 16'd0;
    localparam logic [15:0] POS_XID_END  = 16'd7;
    localparam logic [15:0] POS_YI_END   = 16'd19;
    localparam logic [15:0] POS_MAX      = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_WAIT_OFFER = 3'd1,
        PH_WAIT_ACK   = 3'd2,
        PH_OFFER_DONE = 3'd3,
        PH_ACK_DONE   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        OPT_IDLE  = 2'd0,
        OPT_LEN   = 2'd1,
        OPT_VALUE = 2'd2
    } t_opt_stage;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] packet_length;
        logic        last_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [31:0] client_addr;
        logic [31:0] server_addr;
        logic [31:0] router_addr;
        logic [31:0] netmask;
    } t_out_item;

    typedef struct packed {
        logic        op_ok;
        logic        xid_ok;
        logic [31:0] yiaddr;
        logic        mt_found;
        logic [7:0]  mt;
        logic        srv_found;
        logic [31:0] srv;
        logic        rtr_found;
        logic [31:0] rtr;
        logic        msk_found;
        logic [31:0] msk;
    } t_parse;

endpackage

[hdl/drp_walk.sv]
`timescale 1ns / 1ps
// Per-packet header checks, option walk and value capture.
module drp_walk (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  drp_pkg::t_in_item i_item,
    input  logic [31:0]       i_xid,
    output drp_pkg::t_parse   o_parse
);

    logic [15:0]         r_pos;
    logic [15:0]         r_next;
    logic                r_stop;
    logic [7:0]          r_id;
    drp_pkg::t_opt_stage r_stage;
    logic [31:0]         r_shift;
    drp_pkg::t_parse     r_res;

    logic [15:0]         n_pos;
    logic [15:0]         n_next;
    logic                n_stop;
    logic [7:0]          n_id;
    drp_pkg::t_opt_stage n_stage;
    logic [31:0]         n_shift;
    drp_pkg::t_parse     n_res;

    logic [7:0]  w_b;
    logic [16:0] w_pos_p1;
    logic [16:0] w_end;
    logic        w_want;
    logic        w_at_start;
    logic        w_at_close;
    logic        w_near_end;

    assign w_b        = i_item.data_byte;
    assign w_pos_p1   = {1'b0, r_pos} + 17'd1;
    assign w_end      = w_pos_p1 + {9'd0, w_b};
    assign w_at_start = (r_pos == r_next);
    assign w_at_close = (w_pos_p1 == {1'b0, r_next});
    assign w_near_end = (({1'b0, r_pos} + 17'd5) >= {1'b0, i_item.packet_length});
    assign n_shift    = {r_shift[23:0], w_b};
    assign n_pos      = (r_pos != drp_pkg::POS_MAX) ? w_pos_p1[15:0] : r_pos;

    always_comb begin
        unique case (r_id)
            drp_pkg::OPT_MSGTYPE: w_want = (w_b == drp_pkg::LEN_MSGTYPE);
            drp_pkg::OPT_SERVER,
            drp_pkg::OPT_ROUTER,
            drp_pkg::OPT_NETMASK: w_want = (w_b == drp_pkg::LEN_ADDR);
            default:              w_want = 1'b0;
        endcase
    end

    // next option stage
    always_comb begin
        n_stage = r_stage;
        if (!r_stop) begin
            unique case (r_stage)
                drp_pkg::OPT_LEN:   n_stage = w_want ? drp_pkg::OPT_VALUE : drp_pkg::OPT_IDLE;
                drp_pkg::OPT_VALUE: n_stage = w_at_close ? drp_pkg::OPT_IDLE : r_stage;
                drp_pkg::OPT_IDLE: begin
                    if (w_at_start && w_b != drp_pkg::OPT_PAD_END && !w_near_end) begin
                        n_stage = drp_pkg::OPT_LEN;
                    end
                end
                default:            n_stage = drp_pkg::OPT_IDLE;
            endcase
        end
    end

    // walk and capture data
    always_comb begin
        n_next = r_next;
        n_stop = r_stop;
        n_id   = r_id;
        n_res  = r_res;
        if (r_pos == drp_pkg::POS_OP) begin
            n_res.op_ok = (w_b == drp_pkg::OP_REPLY);
        end
        if (r_pos == drp_pkg::POS_XID_END) begin
            n_res.xid_ok = (n_shift == i_xid);
        end
        if (r_pos == drp_pkg::POS_YI_END) begin
            n_res.yiaddr = n_shift;
        end
        if (!r_stop) begin
            unique case (r_stage)
                drp_pkg::OPT_LEN: begin
                    n_next = w_end[16] ? drp_pkg::POS_MAX : w_end[15:0];
                end
                drp_pkg::OPT_VALUE: begin
                    if (w_at_close) begin
                        priority case (r_id)
                            drp_pkg::OPT_MSGTYPE: begin
                                if (!r_res.mt_found) begin
                                    n_res.mt_found = 1'b1;
                                    n_res.mt       = w_b;
                                end
                            end
                            drp_pkg::OPT_SERVER: begin
                                if (!r_res.srv_found) begin
                                    n_res.srv_found = 1'b1;
                                    n_res.srv       = n_shift;
                                end
                            end
                            drp_pkg::OPT_ROUTER: begin
                                if (!r_res.rtr_found) begin
                                    n_res.rtr_found = 1'b1;
                                    n_res.rtr       = n_shift;
                                end
                            end
                            default: begin
                                if (!r_res.msk_found) begin
                                    n_res.msk_found = 1'b1;
                                    n_res.msk       = n_shift;
                                end
                            end
                        endcase
                    end
                end
                drp_pkg::OPT_IDLE: begin
                    if (w_at_start) begin
                        if (w_b == drp_pkg::OPT_PAD_END || w_near_end) begin
                            n_stop = 1'b1;
                        end else begin
                            n_id = w_b;
                        end
                    end
                end
                default: begin
                    n_next = r_next;
                end
            endcase
        end
    end

    assign o_parse = n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.last_byte)) begin
            r_pos   <= '0;
            r_next  <= drp_pkg::OPT_FIRST;
            r_stop  <= 1'b0;
            r_id    <= '0;
            r_stage <= drp_pkg::OPT_IDLE;
            r_shift <= '0;
            r_res   <= '0;
        end else if (i_step) begin
            r_pos   <= n_pos;
            r_next  <= n_next;
            r_stop  <= n_stop;
            r_id    <= n_id;
            r_stage <= n_stage;
            r_shift <= n_shift;
            r_res   <= n_res;
        end
    end

`ifndef ASSERT_OFF
    a_stop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stop |-> (r_stage == drp_pkg::OPT_IDLE))
        else $error("option walk stopped mid-option");
    a_value_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stage == drp_pkg::OPT_VALUE) |-> (r_id == drp_pkg::OPT_MSGTYPE
            || r_id == drp_pkg::OPT_SERVER || r_id == drp_pkg::OPT_ROUTER
            || r_id == drp_pkg::OPT_NETMASK))
        else $error("capturing an option that is not tracked");
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.last_byte) |=> (r_pos == '0 && r_next == drp_pkg::OPT_FIRST))
        else $error("packet state not cleared after last byte");
`endif

endmodule

[hdl/dhcp_reply_parser_top.sv]
`timescale 1ns / 1ps
// DHCP offer / ack reply parser, top level.
// Takes one payload byte per cycle, sustained, through an input register and then into the result
// register; a byte is refused only while the input register holds a last byte whose result
// cannot yet be written because the result register is full and not taken. The option walk and
// value capture in drp_walk update once per byte. One result leaves on each last byte.
// Configuration writes are always ready and are registered.
module dhcp_reply_parser_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  drp_pkg::t_in_item                  i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output drp_pkg::t_out_item                 o_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [drp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [drp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic               r_in_valid;
    drp_pkg::t_in_item  r_in;
    logic               r_out_valid;
    drp_pkg::t_out_item r_out;
    logic [31:0]        r_xid;
    drp_pkg::t_phase    r_phase;
    drp_pkg::t_phase    n_phase;
    drp_pkg::t_out_item n_out;

    drp_pkg::t_parse w_parse;
    logic            w_adv;
    logic            w_done;
    logic            w_cfg_we;
    logic            w_base_ok;
    logic [1:0]      w_mode;

    assign w_adv       = r_in_valid && (!r_in.last_byte || !r_out_valid || i_out_ready);
    assign w_done      = w_adv && r_in.last_byte;
    assign o_in_ready  = !r_in_valid || w_adv;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid;
    assign w_mode      = i_cfg_data[1:0];
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    drp_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_adv),
        .i_item  (r_in),
        .i_xid   (r_xid),
        .o_parse (w_parse)
    );

    assign w_base_ok = (r_in.packet_length >= drp_pkg::MIN_LEN) && w_parse.op_ok
                       && w_parse.mt_found && w_parse.xid_ok;

    // result for the packet
    always_comb begin
        n_out         = '0;
        n_out.verdict = drp_pkg::VERDICT_NONE;
        unique case (r_phase)
            drp_pkg::PH_WAIT_OFFER: begin
                if (w_base_ok && w_parse.mt == drp_pkg::MT_OFFER && w_parse.srv_found) begin
                    n_out.verdict     = drp_pkg::VERDICT_OFFER;
                    n_out.client_addr = w_parse.yiaddr;
                    n_out.server_addr = w_parse.srv;
                end
            end
            drp_pkg::PH_WAIT_ACK: begin
                if (w_base_ok && w_parse.mt == drp_pkg::MT_ACK) begin
                    n_out.verdict     = drp_pkg::VERDICT_ACK;
                    n_out.client_addr = w_parse.yiaddr;
                    n_out.router_addr = w_parse.rtr_found ? w_parse.rtr : '0;
                    n_out.netmask     = w_parse.msk_found ? w_parse.msk : '0;
                end
            end
            default: begin
                n_out.verdict = drp_pkg::VERDICT_NONE;
            end
        endcase
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (w_cfg_we && i_cfg_index == drp_pkg::CFG_LISTEN_MODE) begin
            unique case (w_mode)
                drp_pkg::MODE_WAIT_OFFER: n_phase = drp_pkg::PH_WAIT_OFFER;
                drp_pkg::MODE_WAIT_ACK:   n_phase = drp_pkg::PH_WAIT_ACK;
                default:                  n_phase = drp_pkg::PH_IDLE;
            endcase
        end else if (w_done && n_out.verdict == drp_pkg::VERDICT_OFFER) begin
            n_phase = drp_pkg::PH_OFFER_DONE;
        end else if (w_done && n_out.verdict == drp_pkg::VERDICT_ACK) begin
            n_phase = drp_pkg::PH_ACK_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_xid       <= '0;
            r_phase     <= drp_pkg::PH_IDLE;
        end else begin
            r_phase <= n_phase;
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_we && i_cfg_index == drp_pkg::CFG_TRANSACTION_ID) begin
                r_xid <= i_cfg_data[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (w_done) begin
            r_out <= n_out;
        end
    end

`ifndef ASSERT_OFF
    a_offer_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && !w_cfg_we && n_out.verdict == drp_pkg::VERDICT_OFFER)
        |=> (r_phase == drp_pkg::PH_OFFER_DONE))
        else $error("accepted offer did not close the phase");
    a_ack_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && !w_cfg_we && n_out.verdict == drp_pkg::VERDICT_ACK)
        |=> (r_phase == drp_pkg::PH_ACK_DONE))
        else $error("accepted ack did not close the phase");
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.verdict == drp_pkg::VERDICT_NONE)
        |-> (r_out.client_addr == '0 && r_out.server_addr == '0))
        else $error("ignored reply carries addresses");
    a_offer_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.verdict == drp_pkg::VERDICT_OFFER)
        |-> (r_out.router_addr == '0 && r_out.netmask == '0))
        else $error("offer carries ack fields");
    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.verdict == drp_pkg::VERDICT_NONE
            || r_out.verdict == drp_pkg::VERDICT_OFFER
            || r_out.verdict == drp_pkg::VERDICT_ACK))
        else $error("undefined verdict code");
`endif

endmodule
